// ===== src/power_circuit_table_current_sum_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the circuit table current sum core
// Shared property forms used by the checker; one assertion per use.
// ----------------------------------------------------------------------------
`ifndef POWER_CIRCUIT_TABLE_CURRENT_SUM_CORE_MACROS_SVH
`define POWER_CIRCUIT_TABLE_CURRENT_SUM_CORE_MACROS_SVH

// Same-cycle implication, silenced while reset is low.
`define PCTS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, silenced while reset is low.
`define PCTS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/pcts_pkg.sv =====
// ----------------------------------------------------------------------------
// pcts_pkg
// Widths, codes and defaults shared by the circuit table current sum core.
// ----------------------------------------------------------------------------
`default_nettype none

package pcts_pkg;

  localparam int TABLE_ENTRIES_DEF = 16;
  localparam int BATTERY_SLOTS_DEF = 4;
  localparam int CFG_REGS          = 4;

  localparam int NODE_W  = 7;
  localparam int CIRC_W  = 16;
  localparam int KEY_W   = NODE_W + CIRC_W;
  localparam int CUR_W   = 21;
  localparam int VOLT_W  = 20;
  localparam int SUM_W   = 25;
  localparam int OUTC_W  = 2;
  localparam int CNT_W   = 3;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = 23;

  // Result outcome codes
  localparam logic [OUTC_W-1:0] OUTC_UPDATED = 2'd0;
  localparam logic [OUTC_W-1:0] OUTC_NEW     = 2'd1;
  localparam logic [OUTC_W-1:0] OUTC_DROPPED = 2'd2;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_IDX_COUNT    = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_IDX_BAT_BASE = 3'd1;

endpackage

`default_nettype wire

// ===== src/pcts_ram.sv =====
// ----------------------------------------------------------------------------
// pcts_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pcts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== src/power_circuit_table_current_sum_core.sv =====
// ----------------------------------------------------------------------------
// power_circuit_table_current_sum_core
// Circuit table with preloaded battery entries and a battery current sum.
// ----------------------------------------------------------------------------
// Each input transfer is one decoded circuit status report. The core walks
// its circuit table one entry per cycle, in index order, and stops at the
// first entry that matches (same node and circuit) or is free; with neither
// the report is dropped. Then it adds up the currents of the battery entries
// one slot per cycle through a single accumulator and presents one result.
// An accepted report holds ready low until its result is handed to the
// output register, so the core takes no new report while one is in work;
// the table walk through the key RAM, with its registered read, takes most
// of that time. A finished result waits in the output register, so the
// next report is taken while it is still unread; only a result that is
// still unread when the next one is finished holds the core in its last
// step. Reset and every write to a listed configuration register rebuild
// the table through the rebuild state, with ready low while it runs; a
// write past the list changes nothing. Battery keys come straight from the
// configuration registers, non-battery keys live in the RAM and are guarded
// by per-entry valid flops.
// ----------------------------------------------------------------------------
`default_nettype none

module power_circuit_table_current_sum_core #(
  parameter int TABLE_ENTRIES = pcts_pkg::TABLE_ENTRIES_DEF,
  parameter int BATTERY_SLOTS = pcts_pkg::BATTERY_SLOTS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // report input
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [pcts_pkg::NODE_W-1:0]         in_source_node,
  input  wire logic [pcts_pkg::CIRC_W-1:0]         in_circuit_number,
  input  wire logic signed [pcts_pkg::CUR_W-1:0]   in_current_ma,
  input  wire logic [pcts_pkg::VOLT_W-1:0]         in_voltage_mv,
  // result output
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [pcts_pkg::SUM_W-1:0]        out_total_current_ma,
  output logic [pcts_pkg::VOLT_W-1:0]              out_supply_mv,
  output logic                                     out_supply_updated,
  output logic [pcts_pkg::OUTC_W-1:0]              out_outcome,
  // configuration writes
  input  wire logic                                cfg_valid,
  output logic                                     cfg_ready,
  input  wire logic [pcts_pkg::CIDX_W-1:0]         cfg_index,
  input  wire logic [pcts_pkg::CDATA_W-1:0]        cfg_data
);

  import pcts_pkg::*;

  // Battery entries in use can never exceed the register count, the slot
  // count or the table size.
  localparam int BAT_A = (CFG_REGS < BATTERY_SLOTS) ? CFG_REGS : BATTERY_SLOTS;
  localparam int BAT_N = (BAT_A < TABLE_ENTRIES) ? BAT_A : TABLE_ENTRIES;
  localparam int PW    = $clog2(TABLE_ENTRIES);
  localparam int SKW   = (BAT_N > 1) ? $clog2(BAT_N) : 1;
  localparam int CW    = (PW > CNT_W) ? PW : CNT_W;

  // Sequencer states
  localparam logic [2:0] ST_CLR  = 3'd0;  // rebuild the table
  localparam logic [2:0] ST_IDLE = 3'd1;  // wait for a report
  localparam logic [2:0] ST_SCAN = 3'd2;  // walk the table
  localparam logic [2:0] ST_UPD  = 3'd3;  // write the chosen entry
  localparam logic [2:0] ST_SUM  = 3'd4;  // accumulate battery currents
  localparam logic [2:0] ST_OUT  = 3'd5;  // hand result to output register

  logic [2:0]              state_r, state_nxt;

  // configuration
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [KEY_W-1:0]        bkey_r [CFG_REGS];
  logic [KEY_W-1:0]        bkey_nxt [CFG_REGS];
  logic [CNT_W-1:0]        n_eff;

  // table state
  logic [TABLE_ENTRIES-1:0] vld_r, vld_nxt;
  logic signed [CUR_W-1:0] bcur_r [BAT_N];
  logic signed [CUR_W-1:0] bcur_nxt [BAT_N];
  logic [VOLT_W-1:0]       supply_r, supply_nxt;

  // item being worked on
  logic [KEY_W-1:0]        key_r, key_nxt;
  logic signed [CUR_W-1:0] cur_r, cur_nxt;
  logic [VOLT_W-1:0]       volt_r, volt_nxt;

  // walk
  logic [PW-1:0]           rd_ptr_r, rd_ptr_nxt;
  logic [PW-1:0]           cmp_ptr_r, cmp_ptr_nxt;
  logic                    cmp_vld_r, cmp_vld_nxt;
  logic [PW-1:0]           idx_r, idx_nxt;
  logic                    is_bat_r, is_bat_nxt;
  logic [OUTC_W-1:0]       outc_r, outc_nxt;
  logic                    upd_r, upd_nxt;

  // sum
  logic [SKW-1:0]          sum_k_r, sum_k_nxt;
  logic signed [SUM_W-1:0] acc_r, acc_nxt;

  // result register
  logic                    out_valid_r, out_valid_nxt;
  logic signed [SUM_W-1:0] out_sum_r, out_sum_nxt;
  logic [VOLT_W-1:0]       out_supply_r, out_supply_nxt;
  logic                    out_upd_r, out_upd_nxt;
  logic [OUTC_W-1:0]       out_outc_r, out_outc_nxt;

  // walk compare signals
  logic [KEY_W-1:0]        ram_rdata;
  logic                    ram_we;
  logic                    cmp_bat;
  logic [KEY_W-1:0]        bat_key;
  logic [KEY_W-1:0]        cmp_key;
  logic                    cmp_valid_bit;
  logic signed [CUR_W-1:0] sum_term;

  // Non-battery circuit keys; only ever read behind a set valid bit.
  pcts_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_ENTRIES)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (idx_r),
    .wr_data (key_r),
    .rd_en   (state_r == ST_SCAN),
    .rd_addr (rd_ptr_r),
    .rd_data (ram_rdata)
  );

  assign ram_we = (state_r == ST_UPD) && (outc_r == OUTC_NEW);

  // Saturate the preload count.
  assign n_eff = (count_r > CNT_W'(BAT_N)) ? CNT_W'(BAT_N) : count_r;

  // Entry under compare: battery entries take their key from the registers.
  assign cmp_bat       = CW'(cmp_ptr_r) < CW'(n_eff);
  assign cmp_valid_bit = vld_r[cmp_ptr_r];
  assign cmp_key       = cmp_bat ? bat_key : ram_rdata;

  always_comb begin
    bat_key  = '0;
    sum_term = '0;
    for (int k = 0; k < BAT_N; k++) begin
      if (cmp_ptr_r == PW'(k)) begin
        bat_key = bkey_r[k];
      end
      if (sum_k_r == SKW'(k)) begin
        sum_term = bcur_r[k];
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    bkey_nxt       = bkey_r;
    vld_nxt        = vld_r;
    bcur_nxt       = bcur_r;
    supply_nxt     = supply_r;
    key_nxt        = key_r;
    cur_nxt        = cur_r;
    volt_nxt       = volt_r;
    rd_ptr_nxt     = rd_ptr_r;
    cmp_ptr_nxt    = cmp_ptr_r;
    cmp_vld_nxt    = cmp_vld_r;
    idx_nxt        = idx_r;
    is_bat_nxt     = is_bat_r;
    outc_nxt       = outc_r;
    upd_nxt        = upd_r;
    sum_k_nxt      = sum_k_r;
    acc_nxt        = acc_r;
    out_valid_nxt  = out_valid_r;
    out_sum_nxt    = out_sum_r;
    out_supply_nxt = out_supply_r;
    out_upd_nxt    = out_upd_r;
    out_outc_nxt   = out_outc_r;

    // drop the result once it transfers
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        // preloaded battery entries valid, everything else free
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          vld_nxt[i] = CW'(i) < CW'(n_eff);
        end
        for (int k = 0; k < BAT_N; k++) begin
          bcur_nxt[k] = '0;
        end
        state_nxt = ST_IDLE;
      end

      ST_IDLE: begin
        if (cfg_valid) begin
          if (cfg_index == CFG_IDX_COUNT) begin
            count_nxt = cfg_data[CNT_W-1:0];
            state_nxt = ST_CLR;
          end
          for (int k = 0; k < CFG_REGS; k++) begin
            if (cfg_index == CFG_IDX_BAT_BASE + CIDX_W'(k)) begin
              bkey_nxt[k] = cfg_data[KEY_W-1:0];
              state_nxt   = ST_CLR;
            end
          end
        end else if (in_valid) begin
          key_nxt     = {in_source_node, in_circuit_number};
          cur_nxt     = in_current_ma;
          volt_nxt    = in_voltage_mv;
          rd_ptr_nxt  = '0;
          cmp_vld_nxt = 1'b0;
          state_nxt   = ST_SCAN;
        end
      end

      ST_SCAN: begin
        // read one entry ahead of the compare
        rd_ptr_nxt  = rd_ptr_r + PW'(1);
        cmp_ptr_nxt = rd_ptr_r;
        cmp_vld_nxt = 1'b1;
        if (cmp_vld_r) begin
          idx_nxt    = cmp_ptr_r;
          is_bat_nxt = cmp_bat;
          if (cmp_valid_bit && (cmp_key == key_r)) begin
            outc_nxt  = OUTC_UPDATED;
            state_nxt = ST_UPD;
          end else if (!cmp_valid_bit) begin
            outc_nxt  = OUTC_NEW;
            state_nxt = ST_UPD;
          end else if (cmp_ptr_r == PW'(TABLE_ENTRIES - 1)) begin
            outc_nxt  = OUTC_DROPPED;
            state_nxt = ST_UPD;
          end
        end
      end

      ST_UPD: begin
        upd_nxt = 1'b0;
        if (outc_r != OUTC_DROPPED) begin
          vld_nxt[idx_r] = 1'b1;
          if (is_bat_r) begin
            for (int k = 0; k < BAT_N; k++) begin
              if (idx_r == PW'(k)) begin
                bcur_nxt[k] = cur_r;
              end
            end
            if (volt_r != '0) begin
              supply_nxt = volt_r;
              upd_nxt    = 1'b1;
            end
          end
        end
        sum_k_nxt = '0;
        acc_nxt   = '0;
        state_nxt = ST_SUM;
      end

      ST_SUM: begin
        if (CW'(sum_k_r) < CW'(n_eff)) begin
          acc_nxt = acc_r + {{(SUM_W - CUR_W){sum_term[CUR_W-1]}}, sum_term};
        end
        sum_k_nxt = sum_k_r + SKW'(1);
        if (sum_k_r == SKW'(BAT_N - 1)) begin
          state_nxt = ST_OUT;
        end
      end

      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_sum_nxt    = acc_r;
          out_supply_nxt = supply_r;
          out_upd_nxt    = upd_r;
          out_outc_nxt   = outc_r;
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      count_r     <= '0;
      bkey_r      <= '{default: '0};
      vld_r       <= '0;
      supply_r    <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      bkey_r      <= bkey_nxt;
      vld_r       <= vld_nxt;
      supply_r    <= supply_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and datapath (battery currents are cleared by the rebuild state)
  always_ff @(posedge clk) begin
    bcur_r       <= bcur_nxt;
    key_r        <= key_nxt;
    cur_r        <= cur_nxt;
    volt_r       <= volt_nxt;
    rd_ptr_r     <= rd_ptr_nxt;
    cmp_ptr_r    <= cmp_ptr_nxt;
    idx_r        <= idx_nxt;
    is_bat_r     <= is_bat_nxt;
    outc_r       <= outc_nxt;
    upd_r        <= upd_nxt;
    sum_k_r      <= sum_k_nxt;
    acc_r        <= acc_nxt;
    out_sum_r    <= out_sum_nxt;
    out_supply_r <= out_supply_nxt;
    out_upd_r    <= out_upd_nxt;
    out_outc_r   <= out_outc_nxt;
  end

  assign in_ready             = (state_r == ST_IDLE) && !cfg_valid;
  assign cfg_ready            = (state_r == ST_IDLE);
  assign out_valid            = out_valid_r;
  assign out_total_current_ma = out_sum_r;
  assign out_supply_mv        = out_supply_r;
  assign out_supply_updated   = out_upd_r;
  assign out_outcome          = out_outc_r;

endmodule

`default_nettype wire

// ===== src/pcts_checker.sv =====
// ----------------------------------------------------------------------------
// pcts_checker
// Port-level checks for the circuit table current sum core, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

`include "power_circuit_table_current_sum_core_macros.svh"

module pcts_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [pcts_pkg::SUM_W-1:0] out_total_current_ma,
  input wire logic [pcts_pkg::VOLT_W-1:0]       out_supply_mv,
  input wire logic                              out_supply_updated,
  input wire logic [pcts_pkg::OUTC_W-1:0]       out_outcome
);

  import pcts_pkg::*;

  // a stalled result holds
  `PCTS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_total_current_ma) && $stable(out_supply_mv) && $stable(out_outcome), "result changed while stalled")

  // the table walk keeps the core busy after a transfer
  `PCTS_ASSERT_NEXT(a_busy_after_in, clk, rst_n, in_valid && in_ready, !in_ready, "ready right after an input transfer")

  // a dropped report never touches the supply voltage
  `PCTS_ASSERT_NOW(a_drop_no_supply, clk, rst_n, out_valid && (out_outcome == OUTC_DROPPED), !out_supply_updated, "dropped report updated supply")

  // a supply update carries a nonzero voltage from a battery entry match
  `PCTS_ASSERT_NOW(a_upd_nonzero, clk, rst_n, out_valid && out_supply_updated, (out_supply_mv != '0) && (out_outcome == OUTC_UPDATED), "bad supply update")

endmodule

bind power_circuit_table_current_sum_core pcts_checker u_pcts_checker (.*);

`default_nettype wire
